### rtl/dbma_pkg.sv
`default_nettype none

package dbma_pkg;

    localparam int ROWS_MAX = 64;
    localparam int COLS_MAX = 64;
    localparam int MAT_DEPTH = ROWS_MAX * COLS_MAX;

    localparam int ROW_W = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int COL_W = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
    localparam int MAT_AW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int ROW_CNT_W = $clog2(ROWS_MAX + 1);
    localparam int COL_CNT_W = $clog2(COLS_MAX + 1);

    localparam int DIM_W = 7;
    localparam int IDX_W = 12;
    localparam int VAL_W = 32;
    localparam int SUM_W = 48;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD_VEC = 2'd0,
        ACT_LOAD_SUM = 2'd1,
        ACT_LOAD_MAT = 2'd2,
        ACT_RUN      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_action                   action;
        logic [IDX_W-1:0]          index;
        logic signed [VAL_W-1:0]   value;
    } t_in_item;

    typedef struct packed {
        logic [5:0]                row;
        logic signed [SUM_W-1:0]   row_sum;
        logic                      last;
    } t_out_item;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
    } t_step;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
    } t_sum_rd;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
        logic [SUM_W-1:0] data;
    } t_sum_wr;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_emit;

    function automatic logic [ROW_CNT_W-1:0] clamp_rows(input logic [DIM_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(ROWS_MAX)) begin
            w = 32'(ROWS_MAX);
        end
        return ROW_CNT_W'(w);
    endfunction

    function automatic logic [COL_CNT_W-1:0] clamp_cols(input logic [DIM_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(COLS_MAX)) begin
            w = 32'(COLS_MAX);
        end
        return COL_CNT_W'(w);
    endfunction

endpackage

`default_nettype wire

### rtl/dense_block_matvec_accumulate.sv
`default_nettype none

// Channel | Direction | Handshake                  | Payload
// input   | in        | i_in_valid / o_in_ready    | i_in_item  (action, index, value)
// output  | out       | o_out_valid / i_out_ready  | o_out_item (row, row_sum, last)
// config  | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A load transaction is written to its store as soon as it is accepted.
// A run steps through rows*cols multiply-accumulates (one matrix word per cycle
// from the matrix memory), drains the pipeline, then emits the rows one at a time,
// each waiting on the registered read of the single row-sum memory port.
// Reset clears control state only; the stores hold nothing until loaded.
// Input stalls only during a run; output stalls hold the current result.

module dense_block_matvec_accumulate (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire dbma_pkg::t_in_item               i_in_item,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output dbma_pkg::t_out_item                   o_out_item,
    input  wire logic                             i_cfg_we,
    input  wire logic [dbma_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [dbma_pkg::DIM_W-1:0]       i_cfg_data
);

    logic [dbma_pkg::DIM_W-1:0] r_rows_cfg;
    logic [dbma_pkg::DIM_W-1:0] r_cols_cfg;
    logic [dbma_pkg::ROW_CNT_W-1:0] rows_eff;
    logic [dbma_pkg::COL_CNT_W-1:0] cols_eff;

    logic in_fire;
    logic run_start;
    logic load_vec;
    logic load_sum;
    logic load_mat;

    dbma_pkg::t_step   step;
    dbma_pkg::t_emit   emit;
    dbma_pkg::t_sum_rd mac_rd;
    dbma_pkg::t_sum_wr mac_wr;
    logic [dbma_pkg::COL_W-1:0]  col;
    logic [dbma_pkg::MAT_AW-1:0] addr;
    logic pipe_busy;
    logic emit_ok;

    logic [dbma_pkg::VAL_W-1:0] mat_rdata;
    logic [dbma_pkg::VAL_W-1:0] vec_rdata;
    logic [dbma_pkg::SUM_W-1:0] sum_rdata;

    logic                       sum_we;
    logic [dbma_pkg::ROW_W-1:0] sum_waddr;
    logic [dbma_pkg::SUM_W-1:0] sum_wdata;
    logic                       sum_re;
    logic [dbma_pkg::ROW_W-1:0] sum_raddr;

    logic                       r_pend;
    logic [dbma_pkg::ROW_W-1:0] r_pend_row;
    logic                       r_pend_last;
    logic                       r_out_valid;
    dbma_pkg::t_out_item        r_out;

    assign in_fire   = i_in_valid && o_in_ready;
    assign run_start = in_fire && (i_in_item.action == dbma_pkg::ACT_RUN);
    assign load_vec  = in_fire && (i_in_item.action == dbma_pkg::ACT_LOAD_VEC)
                       && (32'(i_in_item.index) < 32'(dbma_pkg::COLS_MAX));
    assign load_sum  = in_fire && (i_in_item.action == dbma_pkg::ACT_LOAD_SUM)
                       && (32'(i_in_item.index) < 32'(dbma_pkg::ROWS_MAX));
    assign load_mat  = in_fire && (i_in_item.action == dbma_pkg::ACT_LOAD_MAT)
                       && (32'(i_in_item.index) < 32'(dbma_pkg::MAT_DEPTH));

    assign rows_eff = dbma_pkg::clamp_rows(r_rows_cfg);
    assign cols_eff = dbma_pkg::clamp_cols(r_cols_cfg);

    assign emit_ok = (!r_out_valid || i_out_ready) && !r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= dbma_pkg::DIM_W'(1);
            r_cols_cfg <= dbma_pkg::DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dbma_pkg::CFG_ROWS: r_rows_cfg <= i_cfg_data;
                dbma_pkg::CFG_COLS: r_cols_cfg <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dbma_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (run_start),
        .i_rows      (rows_eff),
        .i_cols      (cols_eff),
        .i_pipe_busy (pipe_busy),
        .i_emit_ok   (emit_ok),
        .o_idle      (o_in_ready),
        .o_step      (step),
        .o_col       (col),
        .o_addr      (addr),
        .o_emit      (emit)
    );

    dbma_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_mat_rdata (mat_rdata),
        .i_vec_rdata (vec_rdata),
        .i_sum_rdata (sum_rdata),
        .o_sum_rd    (mac_rd),
        .o_sum_wr    (mac_wr),
        .o_busy      (pipe_busy)
    );

    dbma_ram #(
        .WIDTH (dbma_pkg::VAL_W),
        .DEPTH (dbma_pkg::MAT_DEPTH)
    ) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (load_mat),
        .i_waddr (dbma_pkg::MAT_AW'(i_in_item.index)),
        .i_wdata (i_in_item.value),
        .i_re    (step.valid),
        .i_raddr (addr),
        .o_rdata (mat_rdata)
    );

    dbma_ram #(
        .WIDTH (dbma_pkg::VAL_W),
        .DEPTH (dbma_pkg::COLS_MAX)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (load_vec),
        .i_waddr (dbma_pkg::COL_W'(i_in_item.index)),
        .i_wdata (i_in_item.value),
        .i_re    (step.valid),
        .i_raddr (col),
        .o_rdata (vec_rdata)
    );

    always_comb begin
        if (load_sum) begin
            sum_we    = 1'b1;
            sum_waddr = dbma_pkg::ROW_W'(i_in_item.index);
            sum_wdata = dbma_pkg::SUM_W'($signed(i_in_item.value));
        end else begin
            sum_we    = mac_wr.en;
            sum_waddr = mac_wr.addr;
            sum_wdata = mac_wr.data;
        end
        if (emit.valid) begin
            sum_re    = 1'b1;
            sum_raddr = emit.row;
        end else begin
            sum_re    = mac_rd.en;
            sum_raddr = mac_rd.addr;
        end
    end

    dbma_ram #(
        .WIDTH (dbma_pkg::SUM_W),
        .DEPTH (dbma_pkg::ROWS_MAX)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (sum_re),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= emit.valid;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_pend_row  <= emit.row;
            r_pend_last <= emit.last;
        end
        if (r_pend) begin
            r_out.row     <= 6'(r_pend_row);
            r_out.row_sum <= $signed(sum_rdata);
            r_out.last    <= r_pend_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

### rtl/dbma_ram.sv
`default_nettype none

module dbma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/dbma_seq.sv
`default_nettype none

module dbma_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [dbma_pkg::ROW_CNT_W-1:0]  i_rows,
    input  wire logic [dbma_pkg::COL_CNT_W-1:0]  i_cols,
    input  wire logic                            i_pipe_busy,
    input  wire logic                            i_emit_ok,
    output logic                                 o_idle,
    output dbma_pkg::t_step                      o_step,
    output logic [dbma_pkg::COL_W-1:0]           o_col,
    output logic [dbma_pkg::MAT_AW-1:0]          o_addr,
    output dbma_pkg::t_emit                      o_emit
);

    dbma_pkg::t_state r_state, n_state;
    logic [dbma_pkg::ROW_W-1:0]  r_row, n_row;
    logic [dbma_pkg::COL_W-1:0]  r_col, n_col;
    logic [dbma_pkg::MAT_AW-1:0] r_addr, n_addr;
    logic last_row;
    logic last_col;

    assign last_row = (r_row == dbma_pkg::ROW_W'(i_rows - 1'b1));
    assign last_col = (r_col == dbma_pkg::COL_W'(i_cols - 1'b1));

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_addr  = r_addr;
        case (r_state)
            dbma_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_row  = '0;
                    n_col  = '0;
                    n_addr = '0;
                    if (i_rows == '0) begin
                        n_state = dbma_pkg::ST_IDLE;
                    end else if (i_cols == '0) begin
                        n_state = dbma_pkg::ST_EMIT;
                    end else begin
                        n_state = dbma_pkg::ST_MAC;
                    end
                end
            end
            dbma_pkg::ST_MAC: begin
                n_addr = r_addr + 1'b1;
                if (last_row) begin
                    n_row = '0;
                    n_col = r_col + 1'b1;
                    if (last_col) begin
                        n_state = dbma_pkg::ST_DRAIN;
                    end
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            dbma_pkg::ST_DRAIN: begin
                n_row = '0;
                if (!i_pipe_busy) begin
                    n_state = dbma_pkg::ST_EMIT;
                end
            end
            dbma_pkg::ST_EMIT: begin
                if (i_emit_ok) begin
                    if (last_row) begin
                        n_row   = '0;
                        n_state = dbma_pkg::ST_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            default: begin
                n_state = dbma_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_idle       = (r_state == dbma_pkg::ST_IDLE);
        o_step.valid = (r_state == dbma_pkg::ST_MAC);
        o_step.row   = r_row;
        o_col        = r_col;
        o_addr       = r_addr;
        o_emit.valid = (r_state == dbma_pkg::ST_EMIT) && i_emit_ok;
        o_emit.row   = r_row;
        o_emit.last  = last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dbma_pkg::ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_addr  <= n_addr;
        end
    end

endmodule

`default_nettype wire

### rtl/dbma_mac.sv
`default_nettype none

module dbma_mac (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire dbma_pkg::t_step              i_step,
    input  wire logic [dbma_pkg::VAL_W-1:0]   i_mat_rdata,
    input  wire logic [dbma_pkg::VAL_W-1:0]   i_vec_rdata,
    input  wire logic [dbma_pkg::SUM_W-1:0]   i_sum_rdata,
    output dbma_pkg::t_sum_rd                 o_sum_rd,
    output dbma_pkg::t_sum_wr                 o_sum_wr,
    output logic                              o_busy
);

    localparam logic signed [dbma_pkg::SUM_W-1:0] SAT_MAX = {1'b0, {(dbma_pkg::SUM_W-1){1'b1}}};
    localparam logic signed [dbma_pkg::SUM_W-1:0] SAT_MIN = {1'b1, {(dbma_pkg::SUM_W-1){1'b0}}};

    dbma_pkg::t_step r_s1;
    dbma_pkg::t_step r_s2;
    logic signed [dbma_pkg::PROD_W-1:0] prod;
    logic signed [dbma_pkg::PROD_W-1:0] r_prod;
    logic                               r_fwd;
    logic signed [dbma_pkg::SUM_W-1:0]  r_fwd_data;
    logic signed [dbma_pkg::SUM_W-1:0]  acc;
    logic signed [dbma_pkg::SUM_W-1:0]  addend;
    logic signed [dbma_pkg::SUM_W:0]    wide_sum;
    logic signed [dbma_pkg::SUM_W-1:0]  sum_new;

    assign prod = $signed(i_mat_rdata) * $signed(i_vec_rdata);

    assign acc      = r_fwd ? r_fwd_data : $signed(i_sum_rdata);
    assign addend   = r_prod[dbma_pkg::FRAC_W +: dbma_pkg::SUM_W];
    assign wide_sum = {acc[dbma_pkg::SUM_W-1], acc} + {addend[dbma_pkg::SUM_W-1], addend};

    always_comb begin
        if (wide_sum[dbma_pkg::SUM_W] != wide_sum[dbma_pkg::SUM_W-1]) begin
            sum_new = wide_sum[dbma_pkg::SUM_W] ? SAT_MIN : SAT_MAX;
        end else begin
            sum_new = wide_sum[dbma_pkg::SUM_W-1:0];
        end
    end

    always_comb begin
        o_sum_rd.en   = r_s1.valid;
        o_sum_rd.addr = r_s1.row;
        o_sum_wr.en   = r_s2.valid;
        o_sum_wr.addr = r_s2.row;
        o_sum_wr.data = sum_new;
        o_busy        = r_s1.valid || r_s2.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_s2  <= '0;
            r_fwd <= 1'b0;
        end else begin
            r_s1  <= i_step;
            r_s2  <= r_s1;
            r_fwd <= r_s1.valid && r_s2.valid && (r_s1.row == r_s2.row);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= prod;
        r_fwd_data <= sum_new;
    end

endmodule

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT = 9;
    localparam int HOLD_CYCLES = 500;
    localparam int SETTLE_CYCLES = 600;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 12;
    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;

    class row_sum_scoreboard;
        logic [dbma_pkg::DIM_W-1:0] rows_reg;
        logic [dbma_pkg::DIM_W-1:0] cols_reg;
        logic signed [dbma_pkg::VAL_W-1:0] vec_mem [dbma_pkg::COLS_MAX];
        logic signed [dbma_pkg::SUM_W-1:0] sum_mem [dbma_pkg::ROWS_MAX];
        logic signed [dbma_pkg::VAL_W-1:0] mat_mem [dbma_pkg::MAT_DEPTH];
        dbma_pkg::t_out_item row_results [$];
        int errors;

        function new();
            rows_reg = 7'd1;
            cols_reg = 7'd1;
            errors = 0;
        endfunction

        function void write_reg(logic [dbma_pkg::CFG_IDX_W-1:0] idx,
                                logic [dbma_pkg::DIM_W-1:0] data);
            if (idx == dbma_pkg::CFG_ROWS) begin
                rows_reg = data;
            end else if (idx == dbma_pkg::CFG_COLS) begin
                cols_reg = data;
            end
        endfunction

        function void note_input(dbma_pkg::t_in_item it);
            int nr;
            int nc;
            longint prod;
            longint acc;
            dbma_pkg::t_out_item row_exp;
            case (it.action)
                dbma_pkg::ACT_LOAD_VEC: begin
                    if (it.index < dbma_pkg::COLS_MAX) begin
                        vec_mem[dbma_pkg::COL_W'(it.index)] = it.value;
                    end
                end
                dbma_pkg::ACT_LOAD_SUM: begin
                    if (it.index < dbma_pkg::ROWS_MAX) begin
                        sum_mem[dbma_pkg::ROW_W'(it.index)] =
                            {{(dbma_pkg::SUM_W - dbma_pkg::VAL_W){it.value[dbma_pkg::VAL_W-1]}},
                             it.value};
                    end
                end
                dbma_pkg::ACT_LOAD_MAT: begin
                    mat_mem[dbma_pkg::MAT_AW'(it.index)] = it.value;
                end
                default: begin
                    nr = (rows_reg > dbma_pkg::ROWS_MAX) ? dbma_pkg::ROWS_MAX : int'(rows_reg);
                    nc = (cols_reg > dbma_pkg::COLS_MAX) ? dbma_pkg::COLS_MAX : int'(cols_reg);
                    for (int j = 0; j < nc; j++) begin
                        for (int i = 0; i < nr; i++) begin
                            prod = (longint'(mat_mem[dbma_pkg::MAT_AW'(j * nr + i)])
                                    * longint'(vec_mem[dbma_pkg::COL_W'(j)])) >>> 16;
                            acc = longint'(sum_mem[dbma_pkg::ROW_W'(i)]) + prod;
                            if (acc > SUM_HI) begin
                                acc = SUM_HI;
                            end else if (acc < SUM_LO) begin
                                acc = SUM_LO;
                            end
                            sum_mem[dbma_pkg::ROW_W'(i)] = dbma_pkg::SUM_W'(acc);
                        end
                    end
                    for (int i = 0; i < nr; i++) begin
                        row_exp.row = 6'(i);
                        row_exp.row_sum = sum_mem[dbma_pkg::ROW_W'(i)];
                        row_exp.last = (i == nr - 1);
                        row_results = {row_results, row_exp};
                    end
                end
            endcase
        endfunction

        function void check_result(dbma_pkg::t_out_item got);
            dbma_pkg::t_out_item want;
            if (row_results.size() == 0) begin
                $error("row result with nothing expected: row %0d row_sum %0d last %0b",
                       got.row, got.row_sum, got.last);
                errors++;
                return;
            end
            want = row_results.pop_front();
            if (got.row !== want.row) begin
                $error("row: expected %0d, actual %0d", want.row, got.row);
                errors++;
            end
            if (got.row_sum !== want.row_sum) begin
                $error("row_sum: expected %0d, actual %0d", want.row_sum, got.row_sum);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    dbma_pkg::t_in_item i_in_item = '0;
    logic i_out_ready = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [dbma_pkg::CFG_IDX_W-1:0] i_cfg_idx = dbma_pkg::CFG_ROWS;
    logic [dbma_pkg::DIM_W-1:0] i_cfg_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    dbma_pkg::t_out_item o_out_item;

    row_sum_scoreboard row_sums = new();
    bit vec_loaded [dbma_pkg::COLS_MAX];
    bit sum_loaded [dbma_pkg::ROWS_MAX];
    bit mat_loaded [dbma_pkg::MAT_DEPTH];
    int eff_rows = 1;
    int eff_cols = 1;
    int useful_items = 0;
    bit no_idle = 1'b0;
    bit hold_go = 1'b0;

    dense_block_matvec_accumulate uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic logic [dbma_pkg::VAL_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: return 32'($urandom_range(262144)) - 32'd131072;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input dbma_pkg::t_action act,
                             input logic [dbma_pkg::IDX_W-1:0] idx,
                             input logic [dbma_pkg::VAL_W-1:0] val);
        dbma_pkg::t_in_item it;
        it.action = act;
        it.index = idx;
        it.value = val;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        row_sums.note_input(it);
        case (act)
            dbma_pkg::ACT_LOAD_VEC: begin
                if (idx < dbma_pkg::COLS_MAX) begin
                    vec_loaded[dbma_pkg::COL_W'(idx)] = 1'b1;
                    useful_items++;
                end
            end
            dbma_pkg::ACT_LOAD_SUM: begin
                if (idx < dbma_pkg::ROWS_MAX) begin
                    sum_loaded[dbma_pkg::ROW_W'(idx)] = 1'b1;
                    useful_items++;
                end
            end
            dbma_pkg::ACT_LOAD_MAT: begin
                mat_loaded[dbma_pkg::MAT_AW'(idx)] = 1'b1;
                useful_items++;
            end
            default: begin
                useful_items++;
            end
        endcase
    endtask

    // A run reads every entry of the current block, so entries never loaded are filled first.
    task automatic run_block();
        for (int j = 0; j < eff_cols; j++) begin
            if (!vec_loaded[dbma_pkg::COL_W'(j)]) begin
                send_item(dbma_pkg::ACT_LOAD_VEC, dbma_pkg::IDX_W'(j), rand_value());
            end
        end
        for (int i = 0; i < eff_rows; i++) begin
            if (!sum_loaded[dbma_pkg::ROW_W'(i)]) begin
                send_item(dbma_pkg::ACT_LOAD_SUM, dbma_pkg::IDX_W'(i), rand_value());
            end
        end
        for (int j = 0; j < eff_cols; j++) begin
            for (int i = 0; i < eff_rows; i++) begin
                if (!mat_loaded[dbma_pkg::MAT_AW'(j * eff_rows + i)]) begin
                    send_item(dbma_pkg::ACT_LOAD_MAT, dbma_pkg::IDX_W'(j * eff_rows + i),
                              rand_value());
                end
            end
        end
        send_item(dbma_pkg::ACT_RUN, dbma_pkg::IDX_W'($urandom), $urandom);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (row_sums.row_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic new_phase(input logic [dbma_pkg::DIM_W-1:0] rows,
                             input logic [dbma_pkg::DIM_W-1:0] cols);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= dbma_pkg::CFG_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        row_sums.write_reg(dbma_pkg::CFG_ROWS, rows);
        i_cfg_idx <= dbma_pkg::CFG_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        row_sums.write_reg(dbma_pkg::CFG_COLS, cols);
        i_cfg_we <= 1'b0;
        eff_rows = (rows > dbma_pkg::ROWS_MAX) ? dbma_pkg::ROWS_MAX : int'(rows);
        eff_cols = (cols > dbma_pkg::COLS_MAX) ? dbma_pkg::COLS_MAX : int'(cols);
    endtask

    task automatic random_phase(input logic [dbma_pkg::DIM_W-1:0] rows,
                                input logic [dbma_pkg::DIM_W-1:0] cols,
                                input bit quiet, input bit squeeze);
        int start;
        int pick;
        dbma_pkg::t_action act;
        new_phase(rows, cols);
        no_idle = quiet;
        start = useful_items;
        if (squeeze) begin
            hold_go = 1'b1;
            run_block();
        end
        while (useful_items - start < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            act = dbma_pkg::t_action'($urandom_range(2));
            if (pick < 12) begin
                run_block();
            end else if (pick < 85) begin
                case (act)
                    dbma_pkg::ACT_LOAD_VEC: send_item(act,
                        dbma_pkg::IDX_W'($urandom_range(eff_cols - 1)), rand_value());
                    dbma_pkg::ACT_LOAD_SUM: send_item(act,
                        dbma_pkg::IDX_W'($urandom_range(eff_rows - 1)), rand_value());
                    default: send_item(act,
                        dbma_pkg::IDX_W'($urandom_range(eff_rows * eff_cols - 1)), rand_value());
                endcase
            end else begin
                send_item(act, dbma_pkg::IDX_W'($urandom), rand_value());
            end
        end
        run_block();
        settle();
        no_idle = 1'b0;
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                row_sums.check_result(o_out_item);
            end
            if (hold_go) begin
                hold_go = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAIL dense_block_matvec_accumulate");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Repeated runs on the largest products drive the sum into both saturation limits.
        send_item(dbma_pkg::ACT_LOAD_VEC, 12'd0, 32'h8000_0000);
        send_item(dbma_pkg::ACT_LOAD_MAT, 12'd0, 32'h8000_0000);
        send_item(dbma_pkg::ACT_LOAD_SUM, 12'd0, 32'h7FFF_FFFF);
        repeat (3) send_item(dbma_pkg::ACT_RUN, 12'd0, 32'h0000_0000);
        send_item(dbma_pkg::ACT_LOAD_VEC, 12'd0, 32'h7FFF_FFFF);
        repeat (5) send_item(dbma_pkg::ACT_RUN, 12'hFFF, 32'hFFFF_FFFF);
        send_item(dbma_pkg::ACT_LOAD_VEC, 12'd64, 32'h1234_5678);
        send_item(dbma_pkg::ACT_LOAD_VEC, 12'hFFF, 32'h7FFF_FFFF);
        send_item(dbma_pkg::ACT_LOAD_SUM, 12'd64, 32'h5555_AAAA);
        send_item(dbma_pkg::ACT_LOAD_SUM, 12'hFFF, 32'hAAAA_5555);
        send_item(dbma_pkg::ACT_LOAD_MAT, 12'hFFF, 32'hFFFF_FFFF);
        send_item(dbma_pkg::ACT_LOAD_SUM, 12'd0, 32'h8000_0000);
        send_item(dbma_pkg::ACT_LOAD_VEC, 12'd0, 32'hFFFF_FFFF);
        send_item(dbma_pkg::ACT_LOAD_MAT, 12'd0, 32'h0000_0001);
        send_item(dbma_pkg::ACT_RUN, 12'd0, 32'h0000_0000);

        new_phase(7'd0, 7'd3);
        run_block();
        run_block();
        new_phase(7'd3, 7'd0);
        run_block();
        new_phase(7'd127, 7'd1);
        run_block();
        new_phase(7'd1, 7'd127);
        run_block();
        run_block();

        random_phase(7'd16, 7'd4, 1'b0, 1'b1);
        random_phase(7'($urandom_range(12, 1)), 7'($urandom_range(8, 1)), 1'b0, 1'b0);
        random_phase(7'($urandom_range(10, 1)), 7'($urandom_range(6, 1)), 1'b1, 1'b0);
        random_phase(7'd64, 7'd2, 1'b0, 1'b0);
        random_phase(7'($urandom_range(20, 1)), 7'($urandom_range(10, 1)), 1'b0, 1'b0);

        settle();
        if (row_sums.errors == 0) begin
            $display("PASS dense_block_matvec_accumulate");
        end else begin
            $display("FAIL dense_block_matvec_accumulate");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/dbma_pkg.sv
rtl/dbma_ram.sv
rtl/dbma_seq.sv
rtl/dbma_mac.sv
rtl/dense_block_matvec_accumulate.sv
bench/tb_top.sv
